// ===== rtl/sib_pkg.sv =====
`timescale 1ns / 1ps

package sib_pkg;

    // Fixed field widths of the sample path and the configuration port.
    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 16;
    localparam int COEF_W     = 18;
    localparam int ORD_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    // Binary point moves: gain Q4.12 into Q24.8, products Q.22 into Q24.8,
    // and Q24.8 into an integer sample.
    localparam int GAIN_SHIFT = 4;
    localparam int ACC_SHIFT  = 14;
    localparam int OUT_SHIFT  = 8;

    // History words go through the multiplier as a low and a high part.
    localparam int LO_W = 16;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_ORDER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FF_COEF0    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FF_COEF1    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FF_COEF2    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FB_COEF1    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FB_COEF2    = 3'd6;

    // Reset values of the registers.
    localparam logic [GAIN_W-1:0] GAIN_RESET  = 16'd4096;
    localparam logic [COEF_W-1:0] COEF0_RESET = 18'd16384;

    // Sequencer states.
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_GAIN  = 6'b000010,
        S_MAC   = 6'b000100,
        S_DRAIN = 6'b001000,
        S_FINAL = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    // One command to the shared multiply-accumulate unit.
    typedef struct packed {
        logic issue;   // multiply this cycle
        logic gain;    // gain times sample, result becomes x[n]
        logic xterm;   // operand is x[n] rather than a history word
        logic sub;     // subtract the product (feedback term)
        logic hi;      // high part of the operand, weight 2^16
        logic clr;     // clear the accumulator
        logic fin;     // capture y[n] from the accumulator
        logic is_y;    // history operand is an output history word
        logic dly;     // history delay index, 0 for one sample back
    } t_mac_op;

    // Handshake and commit controls from the sequencer to the top level.
    typedef struct packed {
        logic in_ready;
        logic load;    // load the output register; commit histories unless pass
        logic pass;    // result is the input sample unchanged
    } t_seq;

endpackage

// ===== rtl/sib_ifs.sv =====
`timescale 1ns / 1ps

// Input sample channel.
interface sib_in_if import sib_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       channel;
    logic signed [SAMPLE_W-1:0] sample_in;

    modport source(output valid, output channel, output sample_in, input ready);
    modport sink(input valid, input channel, input sample_in, output ready);
endinterface

// Filtered sample channel.
interface sib_out_if import sib_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       channel_out;
    logic signed [SAMPLE_W-1:0] sample_out;

    modport source(output valid, output channel_out, output sample_out, input ready);
    modport sink(input valid, input channel_out, input sample_out, output ready);
endinterface

// Configuration write channel.
interface sib_cfg_if import sib_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

// ===== rtl/sib_mac.sv =====
`timescale 1ns / 1ps

module sib_mac import sib_pkg::*; #(
    parameter int HISTORY_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  t_mac_op                         i_op,
    input  logic signed [COEF_W-1:0]        i_coef,
    input  logic signed [SAMPLE_W-1:0]      i_sample,
    input  logic signed [HISTORY_WIDTH-1:0] i_hist,
    output logic signed [HISTORY_WIDTH-1:0] o_x,
    output logic signed [HISTORY_WIDTH-1:0] o_y
);

    localparam int HW  = HISTORY_WIDTH;
    localparam int HIW = HW - LO_W;
    localparam int BW  = (HIW > LO_W + 1) ? HIW : LO_W + 1;
    localparam int PW  = COEF_W + BW;
    localparam int AW  = HW + 21;

    logic signed [HW-1:0]  w_word;
    logic signed [HIW-1:0] w_hi;
    logic signed [LO_W:0]  w_lo;
    logic signed [BW-1:0]  w_b;
    logic signed [PW-1:0]  w_prod;
    logic signed [AW-1:0]  w_pext;
    logic signed [AW-1:0]  w_term;
    logic signed [AW-1:0]  w_gx;

    logic signed [PW-1:0]  r_prod;
    logic                  r_tv;
    logic                  r_tgain;
    logic                  r_tsub;
    logic                  r_thi;
    logic signed [AW-1:0]  r_acc;
    logic signed [HW-1:0]  r_x;
    logic signed [HW-1:0]  r_y;

    // Clamp an accumulator-wide value to the signed history range.
    function automatic logic signed [HW-1:0] f_sat(input logic signed [AW-1:0] v);
        logic fits;
        fits = (&v[AW-1:HW-1]) || !(|v[AW-1:HW-1]);
        if (fits) begin
            return v[HW-1:0];
        end
        return {v[AW-1], {(HW-1){~v[AW-1]}}};
    endfunction

    // Operand selection: sample for the gain step, else one half of a word.
    assign w_word = i_op.xterm ? r_x : i_hist;
    assign w_hi   = w_word[HW-1:LO_W];
    assign w_lo   = signed'({1'b0, w_word[LO_W-1:0]});

    always_comb begin
        if (i_op.gain) begin
            w_b = BW'(i_sample);
        end else if (i_op.hi) begin
            w_b = BW'(w_hi);
        end else begin
            w_b = BW'(w_lo);
        end
    end

    assign w_prod = i_coef * w_b;

    // Product register and the tags that travel with it.
    always_ff @(posedge i_clk) begin
        r_prod  <= w_prod;
        r_tgain <= i_op.gain;
        r_tsub  <= i_op.sub;
        r_thi   <= i_op.hi;
        if (!i_rst_n) begin
            r_tv <= 1'b0;
        end else begin
            r_tv <= i_op.issue;
        end
    end

    // Weight the registered product and form the scaled input.
    assign w_pext = AW'(r_prod);
    assign w_term = r_thi ? (w_pext <<< LO_W) : w_pext;
    assign w_gx   = AW'(r_prod >>> GAIN_SHIFT);

    // Accumulator, scaled input and result capture.
    always_ff @(posedge i_clk) begin
        if (i_op.clr) begin
            r_acc <= '0;
        end else if (r_tv && !r_tgain) begin
            if (r_tsub) begin
                r_acc <= r_acc - w_term;
            end else begin
                r_acc <= r_acc + w_term;
            end
        end
        if (r_tv && r_tgain) begin
            r_x <= f_sat(w_gx);
        end
        if (i_op.fin) begin
            r_y <= f_sat(r_acc >>> ACC_SHIFT);
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;

endmodule

// ===== rtl/sib_hist.sv =====
`timescale 1ns / 1ps

module sib_hist import sib_pkg::*; #(
    parameter int CHANNELS      = 2,
    parameter int MAX_ORDER     = 2,
    parameter int HISTORY_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_chan,
    input  logic                            i_is_y,
    input  logic                            i_dly,
    input  logic                            i_clear,
    input  logic                            i_commit,
    input  logic signed [HISTORY_WIDTH-1:0] i_x,
    input  logic signed [HISTORY_WIDTH-1:0] i_y,
    output logic signed [HISTORY_WIDTH-1:0] o_hist
);

    logic signed [HISTORY_WIDTH-1:0] r_xh [0:CHANNELS-1][0:MAX_ORDER-1];
    logic signed [HISTORY_WIDTH-1:0] r_yh [0:CHANNELS-1][0:MAX_ORDER-1];

    // A channel above the last bank uses the last bank.
    function automatic logic f_bank_hit(input int c, input logic ch);
        if (CHANNELS == 1) begin
            return 1'b1;
        end
        return c == int'(ch);
    endfunction

    // Operand read for the current term.
    always_comb begin
        o_hist = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            for (int d = 0; d < MAX_ORDER; d++) begin
                if (f_bank_hit(c, i_chan) && d == int'(i_dly)) begin
                    o_hist = i_is_y ? r_yh[c][d] : r_xh[c][d];
                end
            end
        end
    end

    // Histories: cleared on reset and on an order change, shifted on commit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            for (int c = 0; c < CHANNELS; c++) begin
                for (int d = 0; d < MAX_ORDER; d++) begin
                    r_xh[c][d] <= '0;
                    r_yh[c][d] <= '0;
                end
            end
        end else if (i_commit) begin
            for (int c = 0; c < CHANNELS; c++) begin
                if (f_bank_hit(c, i_chan)) begin
                    for (int d = 1; d < MAX_ORDER; d++) begin
                        r_xh[c][d] <= r_xh[c][d-1];
                        r_yh[c][d] <= r_yh[c][d-1];
                    end
                    r_xh[c][0] <= i_x;
                    r_yh[c][0] <= i_y;
                end
            end
        end
    end

endmodule

// ===== rtl/sib_ctrl.sv =====
`timescale 1ns / 1ps

module sib_ctrl import sib_pkg::*; #(
    parameter int MAX_ORDER = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [ORD_W-1:0] i_order,
    input  logic             i_out_free,
    output t_mac_op          o_op,
    output t_seq             o_seq
);

    localparam int STEP_N = 2 * (2 * MAX_ORDER + 1);
    localparam int SW     = $clog2(STEP_N);

    t_state        r_state;
    t_state        n_state;
    logic [SW-1:0] r_step;
    logic [SW-1:0] n_step;
    logic          r_pass;
    logic          n_pass;
    logic [SW-1:0] w_last;
    logic [SW-2:0] w_term;
    logic          w_xterm;

    // Two steps per term: history terms first, x[n] last.
    assign w_last  = SW'({i_order, 2'b01});
    assign w_term  = r_step[SW-1:1];
    assign w_xterm = (w_term == (SW-1)'({i_order, 1'b0}));

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_pass  = r_pass;
        o_op    = '0;
        o_seq   = '0;
        o_seq.pass = r_pass;
        unique case (r_state)
            S_IDLE: begin
                o_seq.in_ready = 1'b1;
                if (i_accept) begin
                    n_pass  = (i_order == '0);
                    n_state = (i_order == '0) ? S_OUT : S_GAIN;
                end
            end
            S_GAIN: begin
                o_op.issue = 1'b1;
                o_op.gain  = 1'b1;
                o_op.clr   = 1'b1;
                n_step     = '0;
                n_state    = S_MAC;
            end
            S_MAC: begin
                o_op.issue = 1'b1;
                o_op.hi    = r_step[0];
                o_op.xterm = w_xterm;
                o_op.is_y  = w_term[0];
                o_op.dly   = w_term[1];
                o_op.sub   = !w_xterm && w_term[0];
                if (r_step == w_last) begin
                    n_state = S_DRAIN;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_DRAIN: begin
                n_state = S_FINAL;
            end
            S_FINAL: begin
                o_op.fin = 1'b1;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (i_out_free) begin
                    o_seq.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_pass  <= n_pass;
        end
    end

`ifndef ASSERT_OFF
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_accept) |=> (r_state != S_IDLE))
        else $error("accepted sample did not start processing");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_seq.load |-> i_out_free)
        else $error("output register loaded while still occupied");

    a_step_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC) |-> (r_step <= w_last))
        else $error("step counter passed the last term");

    a_gain_starts_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GAIN) |=> (r_state == S_MAC && r_step == '0))
        else $error("term sequence did not start at the first step");
`endif

endmodule

// ===== rtl/stereo_iir_biquad_filter.sv =====
`timescale 1ns / 1ps
// With filter order N (1 or 2) a sample passes the gain step, a low and a high
// part per term, a drain step and the final capture before it is loaded into the
// output register; with order 0 it is loaded directly. A new sample is taken
// only after that load, as the single shared multiplier does every product.
// Reset (synchronous, active low) restores the register defaults and zeroes
// all histories; a write that changes filter_order zeroes them as well.

module stereo_iir_biquad_filter import sib_pkg::*; #(
    parameter int CHANNELS      = 2,
    parameter int MAX_ORDER     = 2,
    parameter int HISTORY_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sib_in_if.sink     i_sample,
    sib_out_if.source  o_result,
    sib_cfg_if.sink    i_cfg
);

    localparam int HW = HISTORY_WIDTH;

    logic [GAIN_W-1:0]        r_gain;
    logic [ORD_W-1:0]         r_order;
    logic signed [COEF_W-1:0] r_b0;
    logic signed [COEF_W-1:0] r_b1;
    logic signed [COEF_W-1:0] r_b2;
    logic signed [COEF_W-1:0] r_a1;
    logic signed [COEF_W-1:0] r_a2;

    logic                       r_chan;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic                       r_out_valid;
    logic                       r_out_chan;
    logic signed [SAMPLE_W-1:0] r_out_sample;

    logic                       w_cfg_wr;
    logic                       w_hist_clear;
    logic                       w_accept;
    logic                       w_out_free;
    logic [ORD_W-1:0]           w_order;
    t_mac_op                    w_op;
    t_seq                       w_seq;
    logic signed [COEF_W-1:0]   w_coef;
    logic signed [HW-1:0]       w_hist;
    logic signed [HW-1:0]       w_x;
    logic signed [HW-1:0]       w_y;
    logic signed [HW-1:0]       w_ybias;
    logic signed [HW-1:0]       w_yint;
    logic signed [SAMPLE_W-1:0] w_filt;

    // Handshakes.
    assign i_cfg.ready    = 1'b1;
    assign w_cfg_wr       = i_cfg.valid && i_cfg.ready;
    assign i_sample.ready = w_seq.in_ready;
    assign w_accept       = i_sample.valid && i_sample.ready;
    assign w_out_free     = !r_out_valid || o_result.ready;

    // Orders above the built maximum act as the maximum.
    assign w_order = (r_order > ORD_W'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : r_order;

    // A change of order invalidates the stored histories.
    assign w_hist_clear = w_cfg_wr && (i_cfg.index == REG_FILTER_ORDER)
                          && (i_cfg.data[ORD_W-1:0] != r_order);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= GAIN_RESET;
            r_order <= '0;
            r_b0    <= COEF0_RESET;
            r_b1    <= '0;
            r_b2    <= '0;
            r_a1    <= '0;
            r_a2    <= '0;
        end else if (w_cfg_wr) begin
            unique case (i_cfg.index)
                REG_INPUT_GAIN:   r_gain  <= i_cfg.data[GAIN_W-1:0];
                REG_FILTER_ORDER: r_order <= i_cfg.data[ORD_W-1:0];
                REG_FF_COEF0:     r_b0    <= i_cfg.data;
                REG_FF_COEF1:     r_b1    <= i_cfg.data;
                REG_FF_COEF2:     r_b2    <= i_cfg.data;
                REG_FB_COEF1:     r_a1    <= i_cfg.data;
                REG_FB_COEF2:     r_a2    <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // Input sample capture on transfer.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_chan   <= i_sample.channel;
            r_sample <= i_sample.sample_in;
        end
    end

    // Coefficient for the current multiplier step.
    always_comb begin
        priority if (w_op.gain) begin
            w_coef = signed'({{(COEF_W-GAIN_W){1'b0}}, r_gain});
        end else if (w_op.xterm) begin
            w_coef = r_b0;
        end else if (w_op.is_y) begin
            w_coef = w_op.dly ? r_a2 : r_a1;
        end else begin
            w_coef = w_op.dly ? r_b2 : r_b1;
        end
    end

    sib_ctrl #(
        .MAX_ORDER (MAX_ORDER)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_order    (w_order),
        .i_out_free (w_out_free),
        .o_op       (w_op),
        .o_seq      (w_seq)
    );

    sib_mac #(
        .HISTORY_WIDTH (HISTORY_WIDTH)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (w_op),
        .i_coef   (w_coef),
        .i_sample (r_sample),
        .i_hist   (w_hist),
        .o_x      (w_x),
        .o_y      (w_y)
    );

    sib_hist #(
        .CHANNELS      (CHANNELS),
        .MAX_ORDER     (MAX_ORDER),
        .HISTORY_WIDTH (HISTORY_WIDTH)
    ) u_hist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_chan   (r_chan),
        .i_is_y   (w_op.is_y),
        .i_dly    (w_op.dly),
        .i_clear  (w_hist_clear),
        .i_commit (w_seq.load && !w_seq.pass),
        .i_x      (w_x),
        .i_y      (w_y),
        .o_hist   (w_hist)
    );

    // Drop the fraction toward zero, then clamp to the sample range.
    assign w_ybias = w_y[HW-1] ? (w_y + HW'((1 << OUT_SHIFT) - 1)) : w_y;
    assign w_yint  = w_ybias >>> OUT_SHIFT;

    always_comb begin
        if ((&w_yint[HW-1:SAMPLE_W-1]) || !(|w_yint[HW-1:SAMPLE_W-1])) begin
            w_filt = w_yint[SAMPLE_W-1:0];
        end else begin
            w_filt = {w_yint[HW-1], {(SAMPLE_W-1){~w_yint[HW-1]}}};
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_seq.load) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_seq.load) begin
            r_out_chan   <= r_chan;
            r_out_sample <= w_seq.pass ? r_sample : w_filt;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.channel_out = r_out_chan;
    assign o_result.sample_out  = r_out_sample;

endmodule
